>>> rtl/bmf_pkg.sv
// shared constants for the batch median filter
`timescale 1ns / 1ps
`default_nettype none

package bmf_pkg;

	// default depth of the sample store
	localparam int WINDOW_MAX_DEF = 16;
	// default sample width in bits
	localparam int SAMPLE_BITS_DEF = 16;

endpackage

`default_nettype wire

>>> rtl/bmf_store.sv
// sample store: one write port, one synchronous (registered) read port
`timescale 1ns / 1ps
`default_nettype none

module bmf_store #(
	parameter int WINDOW_MAX  = bmf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W = $clog2(WINDOW_MAX)
) (
	input  wire logic                   clk,
	input  wire logic                   we,
	input  wire logic [IDX_W-1:0]       waddr,
	input  wire logic [SAMPLE_BITS-1:0] wdata,
	input  wire logic [IDX_W-1:0]       raddr,
	output logic      [SAMPLE_BITS-1:0] rdata
);

	logic [SAMPLE_BITS-1:0] mem [WINDOW_MAX];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/bmf_out.sv
// result stage: middle-pair average and output register
`timescale 1ns / 1ps
`default_nettype none

module bmf_out #(
	parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF,
	parameter int CNT_W       = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [SAMPLE_BITS-1:0] lo,
	input  wire logic [SAMPLE_BITS-1:0] hi,
	input  wire logic [CNT_W-1:0]       count,
	input  wire logic                   ovf,
	output logic                        can_load,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [SAMPLE_BITS-1:0] median,
	output logic      [CNT_W-1:0]       used_count,
	output logic                        overflowed
);

	logic [SAMPLE_BITS:0] sum;
	logic [SAMPLE_BITS:0] adj;
	logic                 valid_q;
	logic [SAMPLE_BITS-1:0] median_q;
	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;

	// sum of the middle pair, then halve toward zero (add one when negative)
	assign sum = {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi};
	assign adj = sum + {{SAMPLE_BITS{1'b0}}, sum[SAMPLE_BITS]};

	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= adj[SAMPLE_BITS:1];
			count_q  <= count;
			ovf_q    <= ovf;
		end
	end

	assign out_valid  = valid_q;
	assign median     = median_q;
	assign used_count = count_q;
	assign overflowed = ovf_q;

endmodule

`default_nettype wire

>>> rtl/batch_median_filter_top.sv
// batch median filter: sorted sample store, control sequencer and result stage
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  in      | input     | in_valid / in_ready  | sample (signed), last
//  out     | output    | out_valid / out_ready| median (signed), used_count, overflowed
//
// each sample is placed in sorted order as it arrives: the store is walked down
// from the fill point, one read-compare-write per cycle, each larger kept sample
// moving up one slot. the closing item then steps through ST_MED_A, ST_MED_B
// and ST_MED_C to read the middle pair and load the result.
// a dropped sample (store full) is not stored; reset clears count and mark,
// the store itself is left as is. in_ready is low while an item is at work;
// a waiting result stalls the next batch close in ST_MED_C, and intake with it.
`timescale 1ns / 1ps
`default_nettype none

module batch_median_filter_top #(
	parameter int WINDOW_MAX  = bmf_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF,
	localparam int IDX_W = $clog2(WINDOW_MAX),
	localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic                   last,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [SAMPLE_BITS-1:0] median,
	output logic      [CNT_W-1:0]       used_count,
	output logic                        overflowed
);

	localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW_MAX);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SHIFT = 5'b00010,
		ST_MED_A = 5'b00100,
		ST_MED_B = 5'b01000,
		ST_MED_C = 5'b10000
	} state_t;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       fill_q;
	logic                   ovf_q;
	logic [IDX_W-1:0]       pos_q;
	logic [SAMPLE_BITS-1:0] key_q;
	logic                   last_q;
	logic [SAMPLE_BITS-1:0] lo_q;

	logic                   accept;
	logic                   full;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [SAMPLE_BITS-1:0] wdata;
	logic [IDX_W-1:0]       raddr;
	logic [SAMPLE_BITS-1:0] rdata;
	logic                   larger;
	logic [IDX_W-1:0]       lo_idx;
	logic [IDX_W-1:0]       hi_idx;
	logic [CNT_W-1:0]       fill_m1;
	logic                   can_load;
	logic                   load;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (fill_q == FULL);
	assign larger   = $signed(rdata) > $signed(key_q);
	assign load     = (state_q == ST_MED_C) && can_load;

	// middle pair of the sorted store; same entry twice for an odd count
	assign fill_m1 = fill_q - CNT_W'(1);
	assign lo_idx  = IDX_W'(fill_m1 >> 1);
	assign hi_idx  = IDX_W'(fill_q >> 1);

	// sequencer and store port control
	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = key_q;
		raddr   = pos_q - IDX_W'(2);
		case (state_q)
			ST_IDLE: begin
				// look at the current top entry of the sorted run
				raddr = fill_q[IDX_W-1:0] - IDX_W'(1);
				if (accept) begin
					if (!full) begin
						state_d = ST_SHIFT;
					end else if (last) begin
						state_d = ST_MED_A;
					end
				end
			end
			ST_SHIFT: begin
				we = 1'b1;
				if (pos_q != '0 && larger) begin
					// move the larger entry up one slot, read the next one down
					wdata = rdata;
				end else begin
					state_d = last_q ? ST_MED_A : ST_IDLE;
				end
			end
			ST_MED_A: begin
				raddr   = lo_idx;
				state_d = ST_MED_B;
			end
			ST_MED_B: begin
				raddr   = hi_idx;
				state_d = ST_MED_C;
			end
			ST_MED_C: begin
				// hold the read address so the high value stays while stalled
				raddr = hi_idx;
				if (can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			// batch closes once its result is loaded
			if (load) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= sample;
			last_q <= last;
			pos_q  <= fill_q[IDX_W-1:0];
		end else if (state_q == ST_SHIFT && pos_q != '0 && larger) begin
			pos_q <= pos_q - IDX_W'(1);
		end
		if (state_q == ST_MED_B) begin
			lo_q <= rdata;
		end
	end

	bmf_store #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	bmf_out #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CNT_W      (CNT_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.lo        (lo_q),
		.hi        (rdata),
		.count     (fill_q),
		.ovf       (ovf_q),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.used_count(used_count),
		.overflowed(overflowed)
	);

	// fill count never passes the store depth
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FULL)
		else $error("fill count beyond store depth");

	// insertion point stays inside the kept run
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> (CNT_W'(pos_q) < fill_q))
		else $error("insertion point outside kept samples");

	// a closed batch leaves count and mark clear
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (fill_q == '0 && !ovf_q))
		else $error("batch state not cleared after result");

	// a sample that is not last into a full store sets the overflow mark
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && !last) |=> ovf_q)
		else $error("dropped sample did not set overflow mark");

	// a result is only loaded for a nonempty batch
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (fill_q != '0))
		else $error("result loaded for empty batch");

endmodule

`default_nettype wire
